[src/upt_pkg.sv]
// ----------------------------------------------------------------------------
// upt_pkg
// Shared types and constants for the 8E1 UART transceiver.
// ----------------------------------------------------------------------------
package upt_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_BIT_PERIOD  = 2'd0;
  localparam logic [1:0] CFG_START_DELAY = 2'd1;
  localparam logic [1:0] CFG_ENABLE      = 2'd2;

  localparam int          TIMER_W           = 16;
  localparam logic [15:0] BIT_PERIOD_RST    = 16'd416;
  localparam logic [15:0] START_DELAY_RST   = 16'd624;

  // frame bit counters: start is 10, data 9..2, parity 1, stop 0
  localparam logic [3:0] TX_BITS_FRAME = 4'h0A;
  localparam logic [3:0] RX_BITS_FRAME = 4'h09;

  // effective timing, zero already forced to one
  typedef struct packed {
    logic [TIMER_W-1:0] bit_period;
    logic [TIMER_W-1:0] start_delay;
    logic               enable;
  } cfg_t;

  // transmitter status seen by the receiver and the result register
  typedef struct packed {
    logic busy_nxt;
    logic line;
  } tx_stat_t;

  // receiver status and completed byte
  typedef struct packed {
    logic       busy_cur;
    logic       busy_nxt;
    logic       valid;
    logic [7:0] data;
    logic       parity_error;
  } rx_stat_t;

endpackage

[src/upt_in_if.sv]
// ----------------------------------------------------------------------------
// upt_in_if
// Request channel: one clock tick of line sample and send request.
// ----------------------------------------------------------------------------
interface upt_in_if;
  logic       valid;
  logic       ready;
  logic       rx_line;
  logic       send_request;
  logic [7:0] send_byte;

  modport source (output valid, output rx_line, output send_request,
                  output send_byte, input ready);
  modport sink   (input valid, input rx_line, input send_request,
                  input send_byte, output ready);
endinterface

[src/upt_out_if.sv]
// ----------------------------------------------------------------------------
// upt_out_if
// Result channel: line levels, busy flags and received byte per tick.
// ----------------------------------------------------------------------------
interface upt_out_if;
  logic       valid;
  logic       ready;
  logic       tx_line;
  logic       tx_busy;
  logic       rx_busy;
  logic       rx_valid;
  logic [7:0] rx_byte;
  logic       parity_error;

  modport source (output valid, output tx_line, output tx_busy, output rx_busy,
                  output rx_valid, output rx_byte, output parity_error,
                  input ready);
  modport sink   (input valid, input tx_line, input tx_busy, input rx_busy,
                  input rx_valid, input rx_byte, input parity_error,
                  output ready);
endinterface

[src/upt_tx.sv]
// ----------------------------------------------------------------------------
// upt_tx
// Transmit side: frames a byte as start, 8 data LSB first, even parity, stop.
// ----------------------------------------------------------------------------
module upt_tx (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  upt_pkg::cfg_t     cfg,
  input  logic              send_request,
  input  logic [7:0]        send_byte,
  input  logic              rx_busy_cur,
  output upt_pkg::tx_stat_t stat
);

  logic [7:0]                  shift_r, shift_nxt;
  logic                        parity_r, parity_nxt;
  logic [3:0]                  bits_r, bits_nxt;
  logic [upt_pkg::TIMER_W-1:0] timer_r, timer_nxt;
  logic                        out_r, out_nxt;
  logic [upt_pkg::TIMER_W-1:0] timer_dec;
  logic [3:0]                  bits_dec;
  logic                        busy_cur;

  assign busy_cur  = (timer_r != '0);
  assign timer_dec = timer_r - 1'b1;
  assign bits_dec  = bits_r - 1'b1;

  // one tick of the transmitter
  always_comb begin
    shift_nxt  = shift_r;
    parity_nxt = parity_r;
    bits_nxt   = bits_r;
    timer_nxt  = timer_r;
    out_nxt    = out_r;
    if (!cfg.enable) begin
      timer_nxt = '0;
      bits_nxt  = '0;
      out_nxt   = 1'b1;
    end else begin
      // advance running frame
      if (busy_cur) begin
        timer_nxt = timer_dec;
        if (timer_dec == '0) begin
          if (bits_r == '0) begin
            out_nxt = 1'b1;
          end else begin
            bits_nxt = bits_dec;
            if (bits_dec >= 4'd2) begin
              out_nxt   = shift_r[0];
              shift_nxt = {1'b0, shift_r[7:1]};
            end else if (bits_dec == 4'd1) begin
              out_nxt = parity_r;
            end else begin
              out_nxt = 1'b1;
            end
            timer_nxt = cfg.bit_period;
          end
        end
      end
      // new send only while both sides idle
      if (send_request && !busy_cur && !rx_busy_cur) begin
        shift_nxt  = send_byte;
        parity_nxt = ^send_byte;
        bits_nxt   = upt_pkg::TX_BITS_FRAME;
        out_nxt    = 1'b0;
        timer_nxt  = cfg.bit_period;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_r  <= '0;
      timer_r <= '0;
      out_r   <= 1'b1;
    end else if (step) begin
      bits_r  <= bits_nxt;
      timer_r <= timer_nxt;
      out_r   <= out_nxt;
    end
  end

  // frame data
  always_ff @(posedge clk) begin
    if (step) begin
      shift_r  <= shift_nxt;
      parity_r <= parity_nxt;
    end
  end

  assign stat.busy_nxt = (timer_nxt != '0);
  assign stat.line     = out_nxt;

endmodule

[src/upt_rx.sv]
// ----------------------------------------------------------------------------
// upt_rx
// Receive side: start edge detect, mid-bit sampling, even parity check.
// ----------------------------------------------------------------------------
module upt_rx (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  upt_pkg::cfg_t     cfg,
  input  logic              rx_line,
  input  logic              tx_busy_nxt,
  output upt_pkg::rx_stat_t stat
);

  localparam logic [1:0] RX_IDLE   = 2'd0;
  localparam logic [1:0] RX_START  = 2'd1;
  localparam logic [1:0] RX_SAMPLE = 2'd2;

  logic [1:0]                  phase_r, phase_nxt;
  logic [7:0]                  shift_r, shift_nxt;
  logic [3:0]                  bits_r, bits_nxt;
  logic [upt_pkg::TIMER_W-1:0] timer_r, timer_nxt;
  logic                        par_r, par_nxt;
  logic                        prev_r;
  logic [upt_pkg::TIMER_W-1:0] timer_dec;
  logic                        busy_cur;
  logic                        done;

  assign busy_cur  = (phase_r != RX_IDLE);
  assign timer_dec = (timer_r != '0) ? timer_r - 1'b1 : timer_r;

  // one tick of the receiver
  always_comb begin
    phase_nxt = phase_r;
    shift_nxt = shift_r;
    bits_nxt  = bits_r;
    timer_nxt = timer_r;
    par_nxt   = par_r;
    done      = 1'b0;
    if (!cfg.enable) begin
      phase_nxt = RX_IDLE;
      timer_nxt = '0;
      bits_nxt  = '0;
    end else begin
      // sample at bit middles
      if (busy_cur) begin
        timer_nxt = timer_dec;
        if (timer_dec == '0) begin
          if (bits_r >= 4'd2) begin
            shift_nxt = {rx_line, shift_r[7:1]};
          end else if (bits_r == 4'd1) begin
            par_nxt = rx_line;
          end
          if (bits_r == '0) begin
            done      = 1'b1;
            phase_nxt = RX_IDLE;
          end else begin
            bits_nxt  = bits_r - 1'b1;
            timer_nxt = cfg.bit_period;
            phase_nxt = RX_SAMPLE;
          end
        end
      end
      // falling edge starts a frame unless transmitting
      if (!busy_cur && !tx_busy_nxt && prev_r && !rx_line) begin
        phase_nxt = RX_START;
        bits_nxt  = upt_pkg::RX_BITS_FRAME;
        timer_nxt = cfg.start_delay;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= RX_IDLE;
      shift_r <= 8'hFF;
      bits_r  <= '0;
      timer_r <= '0;
      par_r   <= 1'b0;
      prev_r  <= 1'b1;
    end else if (step) begin
      phase_r <= phase_nxt;
      shift_r <= shift_nxt;
      bits_r  <= bits_nxt;
      timer_r <= timer_nxt;
      par_r   <= par_nxt;
      prev_r  <= rx_line;
    end
  end

  assign stat.busy_cur     = busy_cur;
  assign stat.busy_nxt     = (phase_nxt != RX_IDLE);
  assign stat.valid        = done;
  assign stat.data         = done ? shift_r : 8'h00;
  assign stat.parity_error = done & ((^shift_r) ^ par_r);

endmodule

[src/uart_parity_transceiver.sv]
// ----------------------------------------------------------------------------
// uart_parity_transceiver
// Half-duplex 8E1 UART stepped by one request per clock tick.
// ----------------------------------------------------------------------------
// Each request is one tick of the bit timer and yields exactly one result.
// A request is taken every cycle: the transmit and receive state update in
// the accepting cycle and the result lands in a single output register, which
// is refilled in the same cycle it is drained, so the block stalls only while
// that register is full and not taken. Timing (bit_period, start_delay) and
// enable are to be written by the user through the cfg port while the block
// is idle; the block itself does not enforce this. A zero timing value acts as one.
module uart_parity_transceiver (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [15:0]      cfg_data,
  upt_in_if.sink           in_if,
  upt_out_if.source        out_if
);

  logic [upt_pkg::TIMER_W-1:0] bit_period_r;
  logic [upt_pkg::TIMER_W-1:0] start_delay_r;
  logic                        enable_r;
  upt_pkg::cfg_t               cfg;
  upt_pkg::tx_stat_t           tx_stat;
  upt_pkg::rx_stat_t           rx_stat;
  logic                        step;
  logic                        out_valid_r;
  logic                        tx_line_r, tx_busy_r, rx_busy_r, rx_valid_r, perr_r;
  logic [7:0]                  rx_byte_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_period_r  <= upt_pkg::BIT_PERIOD_RST;
      start_delay_r <= upt_pkg::START_DELAY_RST;
      enable_r      <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        upt_pkg::CFG_BIT_PERIOD:  bit_period_r  <= cfg_data;
        upt_pkg::CFG_START_DELAY: start_delay_r <= cfg_data;
        upt_pkg::CFG_ENABLE:      enable_r      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign cfg.bit_period  = (bit_period_r == '0) ? 16'd1 : bit_period_r;
  assign cfg.start_delay = (start_delay_r == '0) ? 16'd1 : start_delay_r;
  assign cfg.enable      = enable_r;

  // request taken whenever the result register is free or draining
  assign in_if.ready = !out_valid_r || out_if.ready;
  assign step        = in_if.valid && in_if.ready;

  upt_tx u_tx (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .cfg          (cfg),
    .send_request (in_if.send_request),
    .send_byte    (in_if.send_byte),
    .rx_busy_cur  (rx_stat.busy_cur),
    .stat         (tx_stat)
  );

  upt_rx u_rx (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .cfg         (cfg),
    .rx_line     (in_if.rx_line),
    .tx_busy_nxt (tx_stat.busy_nxt),
    .stat        (rx_stat)
  );

  // result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      out_valid_r <= step;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (step) begin
      tx_line_r  <= tx_stat.line;
      tx_busy_r  <= tx_stat.busy_nxt;
      rx_busy_r  <= rx_stat.busy_nxt;
      rx_valid_r <= rx_stat.valid;
      rx_byte_r  <= rx_stat.data;
      perr_r     <= rx_stat.parity_error;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.tx_line      = tx_line_r;
  assign out_if.tx_busy      = tx_busy_r;
  assign out_if.rx_busy      = rx_busy_r;
  assign out_if.rx_valid     = rx_valid_r;
  assign out_if.rx_byte      = rx_byte_r;
  assign out_if.parity_error = perr_r;

endmodule
